// ----- rtl/gtg_pkg.sv -----
package gtg_pkg;

  // Counter width that covers the square root steps and up to 32 CORDIC steps.
  localparam int unsigned CntW = 5;

  // Configuration register indexes.
  localparam logic [3:0] RegGoalX    = 4'd0;
  localparam logic [3:0] RegGoalY    = 4'd1;
  localparam logic [3:0] RegDistP    = 4'd2;
  localparam logic [3:0] RegDistI    = 4'd3;
  localparam logic [3:0] RegDistD    = 4'd4;
  localparam logic [3:0] RegHeadP    = 4'd5;
  localparam logic [3:0] RegHeadI    = 4'd6;
  localparam logic [3:0] RegHeadD    = 4'd7;

  // Index of the last square root step: one result bit per step.
  localparam logic [CntW-1:0] SqrtLast = 5'd16;

  // Operand selection for the shared multiplier.
  typedef enum logic [2:0] {
    TermSqX  = 3'd0,
    TermSqY  = 3'd1,
    TermDistP = 3'd2,
    TermDistI = 3'd3,
    TermDistD = 3'd4,
    TermHeadP = 3'd5,
    TermHeadI = 3'd6,
    TermHeadD = 3'd7
  } term_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load;
    logic            sq_en;
    logic            cordic_init;
    logic            sqrt_step;
    logic            cordic_step;
    logic [CntW-1:0] step_idx;
    logic            err_en;
    logic            acc_en;
    logic            acc_clr;
    logic            lin_en;
    logic            fin_en;
    logic            out_load;
    logic            out_drive;
    term_e           term;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic armed;
    logic out_free;
  } sts_t;

  // Arctangent of 2^-i in Q.20.
  function automatic logic [19:0] atan_lut(input logic [CntW-1:0] idx);
    logic [19:0] v;
    unique case (idx)
      5'd0:    v = 20'd823550;
      5'd1:    v = 20'd486171;
      5'd2:    v = 20'd256879;
      5'd3:    v = 20'd130396;
      5'd4:    v = 20'd65451;
      5'd5:    v = 20'd32757;
      5'd6:    v = 20'd16383;
      5'd7:    v = 20'd8192;
      5'd8:    v = 20'd4096;
      5'd9:    v = 20'd2048;
      5'd10:   v = 20'd1024;
      5'd11:   v = 20'd512;
      5'd12:   v = 20'd256;
      5'd13:   v = 20'd128;
      5'd14:   v = 20'd64;
      5'd15:   v = 20'd32;
      5'd16:   v = 20'd16;
      5'd17:   v = 20'd8;
      5'd18:   v = 20'd4;
      5'd19:   v = 20'd2;
      5'd20:   v = 20'd1;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/gtg_datapath.sv -----
module gtg_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [3:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              command_i,
  input  logic [47:0]       pose_i,      // pose_x, pose_y, pose_theta, pad
  input  gtg_pkg::cmd_t     cmd_i,
  output gtg_pkg::sts_t     sts_o,
  input  logic              m_tready_i,
  output logic              m_tvalid_o,
  output logic [31:0]       m_tdata_o,   // linear_velocity, angular_velocity
  output logic [2:0]        m_tuser_o    // goal_accepted, drive_valid, goal_reached
);
  import gtg_pkg::*;

  localparam logic signed [15:0] GoalLimit = 16'sd11264;
  localparam logic signed [25:0] PiQ20     = 26'sd3294199;
  localparam logic signed [17:0] PiQ12     = 18'sd12868;
  localparam logic signed [17:0] TwoPiQ12  = 18'sd25736;
  localparam logic signed [17:0] HeadBand  = 18'sd328;
  localparam logic signed [17:0] DistBand  = 18'sd102;

  // Configuration registers.
  logic signed [15:0] goal_x_q, goal_y_q;
  logic [15:0] dist_p_q, dist_i_q, dist_d_q, head_p_q, head_i_q, head_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q <= 16'sd5677;
      goal_y_q <= 16'sd5677;
      dist_p_q <= 16'd819;
      dist_i_q <= 16'd205;
      dist_d_q <= 16'd82;
      head_p_q <= 16'd6144;
      head_i_q <= 16'd737;
      head_d_q <= 16'd410;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegGoalX: goal_x_q <= cfg_data_i;
        RegGoalY: goal_y_q <= cfg_data_i;
        RegDistP: dist_p_q <= cfg_data_i;
        RegDistI: dist_i_q <= cfg_data_i;
        RegDistD: dist_d_q <= cfg_data_i;
        RegHeadP: head_p_q <= cfg_data_i;
        RegHeadI: head_i_q <= cfg_data_i;
        RegHeadD: head_d_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic in_range;
  assign in_range = (goal_x_q >= -GoalLimit) && (goal_x_q <= GoalLimit) &&
                    (goal_y_q >= -GoalLimit) && (goal_y_q <= GoalLimit);

  // Item capture and position errors.
  logic signed [16:0] ex_q, ey_q;
  logic signed [14:0] theta_q;
  logic               gacc_q;
  logic               armed_q;
  logic signed [15:0] pose_x, pose_y;

  assign pose_x = pose_i[15:0];
  assign pose_y = pose_i[31:16];

  // Shared multiplier.
  logic signed [24:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [41:0] prod;

  logic signed [17:0] dist_q, herr_q, ddist_q, dhead_q, last_dist_q, last_head_q;
  logic signed [23:0] dint_q, hint_q;

  always_comb begin
    mul_a = 25'(ex_q);
    mul_b = ex_q;
    case (cmd_i.term)
      TermSqX:   begin mul_a = 25'(ex_q);    mul_b = ex_q; end
      TermSqY:   begin mul_a = 25'(ey_q);    mul_b = ey_q; end
      TermDistP: begin mul_a = 25'(dist_q);  mul_b = {1'b0, dist_p_q}; end
      TermDistI: begin mul_a = 25'(dint_q);  mul_b = {1'b0, dist_i_q}; end
      TermDistD: begin mul_a = 25'(ddist_q); mul_b = {1'b0, dist_d_q}; end
      TermHeadP: begin mul_a = 25'(herr_q);  mul_b = {1'b0, head_p_q}; end
      TermHeadI: begin mul_a = 25'(hint_q);  mul_b = {1'b0, head_i_q}; end
      TermHeadD: begin mul_a = 25'(dhead_q); mul_b = {1'b0, head_d_q}; end
      default:   begin mul_a = 25'(ex_q);    mul_b = ex_q; end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Sum of squares and square root, one result bit per step.
  logic [33:0] sumsq_q;
  logic [19:0] rem_q, rem_t, trial;
  logic [16:0] root_q;

  assign rem_t = {rem_q[17:0], sumsq_q[33:32]};
  assign trial = {1'b0, root_q, 2'b01};

  // CORDIC vectoring.
  logic signed [44:0] x_q, y_q, xs, ys;
  logic signed [25:0] z_q;
  logic               zero_q;
  logic signed [25:0] atan_v;

  assign xs     = x_q >>> cmd_i.step_idx;
  assign ys     = y_q >>> cmd_i.step_idx;
  assign atan_v = 26'(signed'({1'b0, atan_lut(cmd_i.step_idx)}));

  // Error stage.
  logic signed [25:0] z_rnd;
  logic signed [17:0] bearing, herr_raw, herr_w, dist_s;
  logic signed [24:0] dint_sum, hint_sum;
  logic               dist_in_q, head_in_q;

  assign z_rnd    = z_q + 26'sd128;
  assign bearing  = zero_q ? 18'sd0 : 18'(z_rnd >>> 8);
  assign herr_raw = bearing - 18'(theta_q);
  assign dist_s   = root_q[16] ? 18'sd65535 : {1'b0, root_q};
  assign dint_sum = 25'(dint_q) + 25'(dist_s);
  assign hint_sum = 25'(hint_q) + 25'(herr_w);

  always_comb begin
    herr_w = herr_raw;
    if (herr_raw > PiQ12) begin
      herr_w = herr_raw - TwoPiQ12;
    end else if (herr_raw < -PiQ12) begin
      herr_w = herr_raw + TwoPiQ12;
    end
  end

  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    if (v > 25'sd8388607) return 24'sd8388607;
    if (v < -25'sd8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  // PID accumulation and output scaling.
  logic signed [43:0] acc_q, acc_base;
  logic signed [43:0] acc_rnd;
  logic signed [31:0] vel_s;
  logic signed [15:0] vel_sat, lin_q, ang_q;
  logic               reached_q;

  assign acc_base = cmd_i.acc_clr ? 44'sd0 : acc_q;
  assign acc_rnd  = acc_q + 44'sd2048;
  assign vel_s    = 32'(acc_rnd >>> 12);

  always_comb begin
    if (vel_s > 32'sd32767) begin
      vel_sat = 16'sd32767;
    end else if (vel_s < -32'sd32768) begin
      vel_sat = -16'sd32768;
    end else begin
      vel_sat = vel_s[15:0];
    end
  end

  // Control state of the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      dint_q      <= '0;
      hint_q      <= '0;
      last_dist_q <= '0;
      last_head_q <= '0;
    end else begin
      if (cmd_i.load && command_i && in_range) begin
        armed_q <= 1'b1;
      end else if (cmd_i.fin_en && dist_in_q && head_in_q) begin
        armed_q <= 1'b0;
      end
      if (cmd_i.err_en) begin
        dint_q      <= sat24(dint_sum);
        hint_q      <= sat24(hint_sum);
        last_dist_q <= dist_s;
        last_head_q <= herr_w;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ex_q    <= 17'(goal_x_q) - 17'(pose_x);
      ey_q    <= 17'(goal_y_q) - 17'(pose_y);
      theta_q <= pose_i[46:32];
      gacc_q  <= command_i && in_range;
      rem_q   <= '0;
      root_q  <= '0;
    end
    if (cmd_i.sq_en) begin
      sumsq_q <= ((cmd_i.term == TermSqX) ? 34'd0 : sumsq_q) + prod[33:0];
    end
    if (cmd_i.sqrt_step) begin
      sumsq_q <= {sumsq_q[31:0], 2'b00};
      if (rem_t >= trial) begin
        rem_q  <= rem_t - trial;
        root_q <= {root_q[15:0], 1'b1};
      end else begin
        rem_q  <= rem_t;
        root_q <= {root_q[15:0], 1'b0};
      end
    end
    if (cmd_i.cordic_init) begin
      zero_q <= (ex_q == 17'sd0) && (ey_q == 17'sd0);
      if (ex_q < 17'sd0) begin
        x_q <= -{{4{ex_q[16]}}, ex_q, 24'd0};
        y_q <= -{{4{ey_q[16]}}, ey_q, 24'd0};
        z_q <= (ey_q >= 17'sd0) ? PiQ20 : -PiQ20;
      end else begin
        x_q <= {{4{ex_q[16]}}, ex_q, 24'd0};
        y_q <= {{4{ey_q[16]}}, ey_q, 24'd0};
        z_q <= '0;
      end
    end
    if (cmd_i.cordic_step) begin
      if (y_q >= 45'sd0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_v;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_v;
      end
    end
    if (cmd_i.err_en) begin
      dist_q    <= dist_s;
      herr_q    <= herr_w;
      ddist_q   <= dist_s - last_dist_q;
      dhead_q   <= herr_w - last_head_q;
      dist_in_q <= dist_s < DistBand;
      head_in_q <= (herr_w > -HeadBand) && (herr_w < HeadBand);
    end
    if (cmd_i.acc_en) begin
      acc_q <= acc_base + 44'(prod);
    end
    if (cmd_i.lin_en) begin
      lin_q <= dist_in_q ? 16'sd0 : vel_sat;
    end
    if (cmd_i.fin_en) begin
      ang_q     <= head_in_q ? 16'sd0 : vel_sat;
      reached_q <= dist_in_q && head_in_q;
    end
  end

  // Output register.
  logic        m_valid_q;
  logic [31:0] m_data_q;
  logic [2:0]  m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.out_drive) begin
        m_data_q <= reached_q ? 32'd0 : {ang_q, lin_q};
        m_user_q <= {reached_q, !reached_q, 1'b0};
      end else begin
        m_data_q <= '0;
        m_user_q <= {2'b00, gacc_q};
      end
    end
  end

  assign m_tvalid_o     = m_valid_q;
  assign m_tdata_o      = m_data_q;
  assign m_tuser_o      = m_user_q;
  assign sts_o.armed    = armed_q;
  assign sts_o.out_free = !m_valid_q || m_tready_i;

endmodule

// ----- rtl/gtg_controller.sv -----
module gtg_controller #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  input  logic          command_i,
  output logic          s_tready_o,
  input  gtg_pkg::sts_t sts_i,
  output gtg_pkg::cmd_t cmd_o
);
  import gtg_pkg::*;

  localparam logic [CntW-1:0] CordicLast = CntW'(CORDIC_STEPS - 1);

  typedef enum logic [8:0] {
    StIdle = 9'b000000001,
    StSqX  = 9'b000000010,
    StSqY  = 9'b000000100,
    StSqrt = 9'b000001000,
    StCord = 9'b000010000,
    StErr  = 9'b000100000,
    StPid  = 9'b001000000,
    StFin  = 9'b010000000,
    StDone = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            drive_q, drive_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      drive_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drive_q <= drive_d;
    end
  end

  // Sequencing of one item through the datapath.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    drive_d    = drive_q;
    s_tready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.term = TermSqX;
    cmd_o.step_idx  = cnt_q;
    cmd_o.out_drive = drive_q;
    unique case (state_q)
      StIdle: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          if (command_i || !sts_i.armed) begin
            drive_d = 1'b0;
            state_d = StDone;
          end else begin
            drive_d = 1'b1;
            state_d = StSqX;
          end
        end
      end
      StSqX: begin
        cmd_o.sq_en       = 1'b1;
        cmd_o.term        = TermSqX;
        cmd_o.cordic_init = 1'b1;
        state_d           = StSqY;
      end
      StSqY: begin
        cmd_o.sq_en = 1'b1;
        cmd_o.term  = TermSqY;
        state_d     = StSqrt;
      end
      StSqrt: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == SqrtLast) begin
          cnt_d   = '0;
          state_d = StCord;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StCord: begin
        cmd_o.cordic_step = 1'b1;
        if (cnt_q == CordicLast) begin
          cnt_d   = '0;
          state_d = StErr;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StErr: begin
        cmd_o.err_en = 1'b1;
        state_d      = StPid;
      end
      StPid: begin
        cmd_o.acc_en = 1'b1;
        case (cnt_q)
          5'd0:    cmd_o.term = TermDistP;
          5'd1:    cmd_o.term = TermDistI;
          5'd2:    cmd_o.term = TermDistD;
          5'd3:    cmd_o.term = TermHeadP;
          5'd4:    cmd_o.term = TermHeadI;
          default: cmd_o.term = TermHeadD;
        endcase
        // The distance sum is complete when the heading terms begin.
        cmd_o.acc_clr = (cnt_q == 5'd0) || (cnt_q == 5'd3);
        cmd_o.lin_en  = (cnt_q == 5'd3);
        if (cnt_q == 5'd5) begin
          cnt_d   = '0;
          state_d = StFin;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StFin: begin
        cmd_o.fin_en = 1'b1;
        state_d      = StDone;
      end
      StDone: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

// ----- rtl/go_to_goal_pid_controller.sv -----
// Go-to-goal PID controller for a unicycle robot. A beat with tuser set is a
// start command that arms the target held in goal_x/goal_y when both lie
// within plus or minus 11.0; every other beat is a pose sample that, while
// armed, yields linear and angular velocity commands from a distance and a
// heading PID loop. Start commands and samples taken while disarmed go from
// idle straight to the output stage. An armed sample passes through the
// bit-serial square root (17 steps) and the CORDIC bearing unit (one step per
// cycle), followed by six passes through the one shared multiplier. One item
// is in work at a time; the next beat is taken while a finished result still
// waits in the output register.
module go_to_goal_pid_controller #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // pose_x, pose_y, pose_theta, zero pad
  input  logic        s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // linear_velocity, angular_velocity
  output logic [2:0]  m_axis_tuser    // goal_accepted, drive_valid, goal_reached
);
  import gtg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  gtg_controller #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .command_i  (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gtg_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .command_i   (s_axis_tuser),
    .pose_i      (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import gtg_pkg::*;

  // Register index that decodes to no register.
  localparam logic [3:0] RegUnused = 4'd9;
  localparam int unsigned BearingSteps = 16;
  localparam int DistBand = 102;
  localparam int HeadBand = 328;
  localparam int GoalLimit = 11264;
  localparam longint PiQ12 = 12868;
  localparam longint TwoPiQ12 = 25736;
  localparam longint PiQ20 = 3294199;
  localparam longint Int24Max = 8388607;
  localparam longint Int24Min = -8388608;
  localparam int DrainCycles = 100;

  localparam longint AtanQ20 [24] = '{
    823550, 486171, 256879, 130396, 65451, 32757, 16383, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 0, 0, 0
  };

  typedef struct packed {
    logic        accepted;
    logic        drive;
    logic [15:0] lin_vel;
    logic [15:0] ang_vel;
    logic        reached;
  } drive_cmd_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  // Controller state as the predictor sees it.
  logic [15:0] gain_goal_q [8];
  logic        armed_q;
  longint      dist_integ_q;
  longint      head_integ_q;
  longint      last_dist_q;
  longint      last_head_q;

  drive_cmd_t  pending_cmds [$];
  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  go_to_goal_pid_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    #50ms;
    $display("go_to_goal_pid_controller regression: fail");
    $finish;
  end

  // One PID sum, rounded to Q6.10 and saturated.
  function automatic longint pid_velocity(longint err, longint integ, longint derr,
                                          logic [15:0] kp, logic [15:0] ki,
                                          logic [15:0] kd);
    longint s;
    s = longint'(kp) * err + longint'(ki) * integ + longint'(kd) * derr;
    s = (s + 2048) >>> 12;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return s;
  endfunction

  // Expected reply to one beat; updates the controller state.
  function automatic drive_cmd_t predict_drive(logic cmd, logic [15:0] px,
                                               logic [15:0] py, logic [14:0] th);
    drive_cmd_t r;
    longint gx, gy, ex, ey, dist_err, herr, x, y, z, xs, ys, lv, av;
    longint unsigned n, root, bt;
    logic dist_in, head_in;
    r = '0;
    gx = longint'($signed(gain_goal_q[RegGoalX]));
    gy = longint'($signed(gain_goal_q[RegGoalY]));
    if (cmd) begin
      if (gx >= -GoalLimit && gx <= GoalLimit && gy >= -GoalLimit && gy <= GoalLimit) begin
        armed_q = 1'b1;
        r.accepted = 1'b1;
      end
      return r;
    end
    if (!armed_q) return r;
    ex = gx - longint'($signed(px));
    ey = gy - longint'($signed(py));
    // Integer square root of the squared range.
    n = ex * ex + ey * ey;
    root = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= root + bt) begin
        n = n - (root + bt);
        root = (root >> 1) + bt;
      end else begin
        root = root >> 1;
      end
      bt = bt >> 2;
    end
    dist_err = (root > 65535) ? 65535 : longint'(root);
    // Bearing by CORDIC vectoring in Q.20.
    z = 0;
    if (ex != 0 || ey != 0) begin
      x = ex * 16777216;
      y = ey * 16777216;
      if (x < 0) begin
        z = (ey >= 0) ? PiQ20 : -PiQ20;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < BearingSteps; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += AtanQ20[i];
        end else begin
          x -= ys; y += xs; z -= AtanQ20[i];
        end
      end
      z = (z + 128) >>> 8;
    end
    herr = z - longint'($signed(th));
    if (herr > PiQ12) herr -= TwoPiQ12;
    else if (herr < -PiQ12) herr += TwoPiQ12;
    // Saturating integrals.
    dist_integ_q += dist_err;
    if (dist_integ_q > Int24Max) dist_integ_q = Int24Max;
    head_integ_q += herr;
    if (head_integ_q > Int24Max) head_integ_q = Int24Max;
    if (head_integ_q < Int24Min) head_integ_q = Int24Min;
    dist_in = dist_err < DistBand;
    head_in = ((herr < 0) ? -herr : herr) < HeadBand;
    lv = dist_in ? 0 : pid_velocity(dist_err, dist_integ_q, dist_err - last_dist_q,
                                    gain_goal_q[RegDistP], gain_goal_q[RegDistI],
                                    gain_goal_q[RegDistD]);
    av = head_in ? 0 : pid_velocity(herr, head_integ_q, herr - last_head_q,
                                    gain_goal_q[RegHeadP], gain_goal_q[RegHeadI],
                                    gain_goal_q[RegHeadD]);
    last_dist_q = dist_err;
    last_head_q = herr;
    if (dist_in && head_in) begin
      armed_q = 1'b0;
      r.reached = 1'b1;
    end else begin
      r.drive = 1'b1;
      r.lin_vel = lv[15:0];
      r.ang_vel = av[15:0];
    end
    return r;
  endfunction

  // Result checker: every accepted beat against the oldest expectation.
  always @(posedge clk_i) begin
    drive_cmd_t exp_cmd, got_cmd;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_cmd = {m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata[15:0],
                 m_axis_tdata[31:16], m_axis_tuser[2]};
      if (pending_cmds.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result beat %h", $time, got_cmd);
      end else begin
        exp_cmd = pending_cmds.pop_front();
        if (got_cmd.accepted !== exp_cmd.accepted || got_cmd.drive !== exp_cmd.drive ||
            got_cmd.lin_vel !== exp_cmd.lin_vel || got_cmd.ang_vel !== exp_cmd.ang_vel ||
            got_cmd.reached !== exp_cmd.reached) begin
          fail_count++;
          $display("%0t: mismatch expected acc=%b drv=%b lin=%h ang=%h rch=%b",
                   $time, exp_cmd.accepted, exp_cmd.drive, exp_cmd.lin_vel,
                   exp_cmd.ang_vel, exp_cmd.reached);
          $display("%0t:          actual   acc=%b drv=%b lin=%h ang=%h rch=%b",
                   $time, got_cmd.accepted, got_cmd.drive, got_cmd.lin_vel,
                   got_cmd.ang_vel, got_cmd.reached);
        end
      end
    end
  end

  // Receiver back-pressure.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Send one beat and record its expected reply.
  task automatic send_pose(logic cmd, logic [15:0] px, logic [15:0] py, logic [14:0] th);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, th, py, px};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_cmds.push_back(predict_drive(cmd, px, py, th));
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every reply has come back.
  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx < 8) gain_goal_q[idx] = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // A pose close to the goal, sometimes right on it and facing nearly along.
  task automatic send_near_goal();
    logic [15:0] px, py;
    logic [14:0] th;
    int spread;
    spread = ($urandom_range(3) == 0) ? 0 : ($urandom_range(1) ? 70 : 3000);
    px = gain_goal_q[RegGoalX] + 16'($signed($urandom_range(2 * spread)) - spread);
    py = gain_goal_q[RegGoalY] + 16'($signed($urandom_range(2 * spread)) - spread);
    th = (spread == 0) ? 15'($signed($urandom_range(700)) - 350) : 15'($urandom);
    send_pose(1'b0, px, py, th);
  endtask

  // Defaults after reset: disarmed sample, start, a few samples.
  task automatic test_reset_defaults();
    send_pose(1'b0, 16'h0000, 16'h0000, 15'h0000);
    send_pose(1'b1, 16'h0000, 16'h0000, 15'h0000);
    send_pose(1'b0, 16'h0000, 16'h0000, 15'h0000);
    send_pose(1'b0, 16'h1000, 16'hF000, 15'h3000);
    send_pose(1'b0, 16'd5677, 16'd5677, 15'h0000);
    drain_replies();
  endtask

  // Field extremes, rejected starts, zero vector, unknown index, live target.
  task automatic test_corner_cases();
    write_reg(RegUnused, 16'hFFFF);
    write_reg(RegGoalX, 16'h8000);
    write_reg(RegGoalY, 16'h7FFF);
    send_pose(1'b1, 16'h0000, 16'h0000, 15'h0000);
    send_pose(1'b0, 16'h7FFF, 16'h8000, 15'h3FFF);
    drain_replies();
    write_reg(RegGoalX, 16'(GoalLimit));
    write_reg(RegGoalY, 16'(-GoalLimit));
    send_pose(1'b1, 16'hFFFF, 16'hFFFF, 15'h7FFF);
    send_pose(1'b0, 16'h8000, 16'h7FFF, 15'h4000);
    send_pose(1'b0, 16'h7FFF, 16'h8000, 15'h3FFF);
    send_pose(1'b0, 16'(-GoalLimit), 16'(GoalLimit), 15'h4000);
    send_pose(1'b0, 16'(GoalLimit), 16'(-GoalLimit), 15'h0000);
    drain_replies();
    write_reg(RegGoalY, 16'(-GoalLimit - 1));
    send_pose(1'b1, 16'h0000, 16'h0000, 15'h0000);
    send_pose(1'b0, 16'h0100, 16'h0100, 15'h0000);
    drain_replies();
    // Live target: the goal moves while disarmed, and later starts arm the moved goal.
    write_reg(RegGoalY, 16'h0000);
    send_pose(1'b0, 16'h0000, 16'h0000, 15'h0200);
    drain_replies();
    write_reg(RegGoalX, 16'h0400);
    send_pose(1'b0, 16'h0000, 16'h0400, 15'h0000);
    send_pose(1'b0, 16'h0400, 16'h0000, 15'h0000);
    send_pose(1'b1, 16'h0000, 16'h0000, 15'h0000);
    send_pose(1'b1, 16'h0000, 16'h0000, 15'h0000);
    drain_replies();
  endtask

  // Random phase: new registers, then mostly approaches to the goal.
  task automatic test_random_phase(int idle_pct, int stall_pct, int gain_mode, int items);
    logic [15:0] g;
    for (int r = 0; r < 8; r++) begin
      if (r < 2) g = 16'($signed($urandom_range(24000)) - 12000);
      else if (gain_mode == 0) g = 16'h0000;
      else if (gain_mode == 1) g = 16'hFFFF;
      else g = 16'($urandom_range(8191));
      write_reg(r[3:0], g);
    end
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(99) < 8)
        send_pose(1'b1, 16'($urandom), 16'($urandom), 15'($urandom));
      else if ($urandom_range(99) < 6)
        send_pose(1'b0, 16'($urandom), 16'($urandom), 15'($urandom));
      else
        send_near_goal();
      // Hold off until every reply is in.
      if (i == items / 2) begin
        s_axis_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) @(negedge clk_i);
      end
    end
    drain_replies();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    gain_goal_q   = '{16'd5677, 16'd5677, 16'd819, 16'd205, 16'd82,
                      16'd6144, 16'd737, 16'd410};
    armed_q       = 1'b0;
    dist_integ_q  = 0;
    head_integ_q  = 0;
    last_dist_q   = 0;
    last_head_q   = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_corner_cases();
    test_random_phase(0, 0, 2, 400);
    test_random_phase(46, 0, 1, 400);
    test_random_phase(0, 46, 0, 400);
    test_random_phase(19, 19, 2, 400);

    if (fail_count == 0) begin
      $display("go_to_goal_pid_controller regression: pass");
    end else begin
      $display("go_to_goal_pid_controller regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/gtg_pkg.sv
rtl/gtg_datapath.sv
rtl/gtg_controller.sv
rtl/go_to_goal_pid_controller.sv
dv/testbench.sv
